// ===== design/force_torque_gravity_compensation_assert.svh =====
// assertion macros used by the port-level checker
`ifndef FORCE_TORQUE_GRAVITY_COMPENSATION_ASSERT_SVH
`define FORCE_TORQUE_GRAVITY_COMPENSATION_ASSERT_SVH

// same-cycle implication, quiet during reset
`define FTGC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, quiet during reset
`define FTGC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// next-cycle implication, checked through reset as well
`define FTGC_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== design/ftgc_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ftgc_pkg
// Types, constants and fixed-point helpers for the gravity compensation block.
// ---------------------------------------------------------------------------
package ftgc_pkg;

  localparam int FORCE_BITS    = 24;
  localparam int ROT_FRAC_BITS = 14;
  localparam int ELEM_BITS     = 16;
  localparam int WORD_BITS     = 3 * ELEM_BITS;
  localparam int ACC_BITS      = 48;
  localparam int VAL_BITS      = 32;
  localparam int CFG_IDX_BITS  = 3;

  localparam logic OP_MEASURE   = 1'b0;
  localparam logic OP_CALIBRATE = 1'b1;

  localparam logic [CFG_IDX_BITS-1:0] REG_SENSOR_ROT_ROW0 = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SENSOR_ROT_ROW1 = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_SENSOR_ROT_ROW2 = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_SENSOR_OFFSET   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_TOOL_WEIGHT     = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_GRAVITY_POINT   = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_RIGHT_HANDED    = 3'd6;

  localparam logic [WORD_BITS-1:0] ROT_ROW0_RESET = 48'h4000_0000_0000;
  localparam logic [WORD_BITS-1:0] ROT_ROW1_RESET = 48'h0000_4000_0000;
  localparam logic [WORD_BITS-1:0] ROT_ROW2_RESET = 48'h0000_0000_4000;

  typedef logic signed [FORCE_BITS-1:0] force_t;
  typedef logic signed [FORCE_BITS:0]   wide_t;
  typedef logic signed [VAL_BITS-1:0]   val_t;
  typedef logic signed [ACC_BITS-1:0]   acc_t;
  typedef logic [WORD_BITS-1:0]         word_t;

  typedef struct packed {
    logic   op;
    force_t force_x;
    force_t force_y;
    force_t force_z;
    force_t torque_x;
    force_t torque_y;
    force_t torque_z;
    word_t  wrist_rot_row0;
    word_t  wrist_rot_row1;
    word_t  wrist_rot_row2;
  } in_item_t;

  typedef struct packed {
    force_t out_force_x;
    force_t out_force_y;
    force_t out_force_z;
    force_t out_torque_x;
    force_t out_torque_y;
    force_t out_torque_z;
  } out_item_t;

  // item after handedness correction, as held in the queue
  typedef struct packed {
    logic  op;
    wide_t fx;
    wide_t fy;
    wide_t fz;
    wide_t tx;
    wide_t ty;
    wide_t tz;
    word_t r0;
    word_t r1;
    word_t r2;
  } queue_item_t;

  typedef struct packed {
    word_t                 rot_row0;
    word_t                 rot_row1;
    word_t                 rot_row2;
    word_t                 offset;
    logic [FORCE_BITS-2:0] weight;
    word_t                 grav_point;
  } back_cfg_t;

  function automatic logic signed [ELEM_BITS-1:0] elem(input word_t w, input int c);
    return w[WORD_BITS-1-ELEM_BITS*c -: ELEM_BITS];
  endfunction

  function automatic acc_t mul(input logic signed [ELEM_BITS-1:0] a, input val_t v);
    acc_t ax;
    acc_t vx;
    ax = ACC_BITS'(a);
    vx = ACC_BITS'(v);
    return ax * vx;
  endfunction

  // round half up after dropping the fraction bits
  function automatic val_t rnd(input acc_t x);
    acc_t y;
    y = x + (acc_t'(1) <<< (ROT_FRAC_BITS - 1));
    y = y >>> ROT_FRAC_BITS;
    return y[VAL_BITS-1:0];
  endfunction

  function automatic val_t dot3(input word_t row, input val_t a, input val_t b,
                                input val_t c);
    return rnd(mul(elem(row, 0), a) + mul(elem(row, 1), b) + mul(elem(row, 2), c));
  endfunction

  function automatic val_t cross_c(input logic signed [ELEM_BITS-1:0] pa,
                                   input val_t vb,
                                   input logic signed [ELEM_BITS-1:0] pb,
                                   input val_t va);
    return rnd(mul(pa, vb) - mul(pb, va));
  endfunction

  function automatic force_t sat(input val_t x);
    val_t hi;
    val_t lo;
    hi = val_t'((64'sd1 <<< (FORCE_BITS - 1)) - 64'sd1);
    lo = -hi - val_t'(1);
    if (x > hi) begin
      return hi[FORCE_BITS-1:0];
    end else if (x < lo) begin
      return lo[FORCE_BITS-1:0];
    end
    return x[FORCE_BITS-1:0];
  endfunction

endpackage

// ===== design/force_torque_gravity_compensation.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// force_torque_gravity_compensation
// Six-axis wrench gravity compensation: register file, front queue, back pipe.
// ---------------------------------------------------------------------------
// channel   direction  handshake            payload
// in        input      in_valid / in_ready  in_item  (in_item_t)
// out       output     out_valid/ out_ready out_item (out_item_t)
// cfg       input      cfg_we               cfg_index, cfg_data
//
// one item per cycle sustained unless the result stalls; an item taken
// on an empty queue passes queue entry, stage a, stage b, result register.
// the back pipeline has three multiply stages: a, b and the result register.
// the queue holds QUEUE_DEPTH items; in_ready drops only when it is full.
// a stalled result freezes the whole back pipeline; the queue keeps filling.
// synchronous reset restores register defaults and clears the reaction.
module force_torque_gravity_compensation #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  ftgc_pkg::in_item_t                  in_item,
  output logic                                out_valid,
  input  logic                                out_ready,
  output ftgc_pkg::out_item_t                 out_item,
  input  logic                                cfg_we,
  input  logic [ftgc_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [ftgc_pkg::WORD_BITS-1:0]      cfg_data
);

  ftgc_pkg::back_cfg_t   cfg;
  logic                  right_handed;
  logic                  head_valid;
  ftgc_pkg::queue_item_t head;
  logic                  pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rot_row0   <= ftgc_pkg::ROT_ROW0_RESET;
      cfg.rot_row1   <= ftgc_pkg::ROT_ROW1_RESET;
      cfg.rot_row2   <= ftgc_pkg::ROT_ROW2_RESET;
      cfg.offset     <= '0;
      cfg.weight     <= '0;
      cfg.grav_point <= '0;
      right_handed   <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        ftgc_pkg::REG_SENSOR_ROT_ROW0: cfg.rot_row0 <= cfg_data;
        ftgc_pkg::REG_SENSOR_ROT_ROW1: cfg.rot_row1 <= cfg_data;
        ftgc_pkg::REG_SENSOR_ROT_ROW2: cfg.rot_row2 <= cfg_data;
        ftgc_pkg::REG_SENSOR_OFFSET:   cfg.offset   <= cfg_data;
        ftgc_pkg::REG_TOOL_WEIGHT:     cfg.weight   <= cfg_data[ftgc_pkg::FORCE_BITS-2:0];
        ftgc_pkg::REG_GRAVITY_POINT:   cfg.grav_point <= cfg_data;
        ftgc_pkg::REG_RIGHT_HANDED:    right_handed <= cfg_data[0];
        default: ;
      endcase
    end
  end

  ftgc_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_item),
    .right_handed(right_handed),
    .head_valid  (head_valid),
    .head        (head),
    .pop         (pop)
  );

  ftgc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head_valid(head_valid),
    .head      (head),
    .pop       (pop),
    .cfg       (cfg),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

// ===== design/ftgc_front.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ftgc_front
// Input handshake, handedness correction and the item queue to the back end.
// ---------------------------------------------------------------------------
module ftgc_front #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ftgc_pkg::in_item_t    in_item,
  input  logic                  right_handed,
  output logic                  head_valid,
  output ftgc_pkg::queue_item_t head,
  input  logic                  pop
);

  localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  ftgc_pkg::queue_item_t entries [QUEUE_DEPTH];
  logic [PTR_BITS-1:0]   wr_ptr;
  logic [PTR_BITS-1:0]   rd_ptr;
  logic [CNT_BITS-1:0]   count;
  ftgc_pkg::queue_item_t classified;
  logic                  push;
  logic                  do_pop;

  assign in_ready   = (count != CNT_BITS'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];
  assign push       = in_valid && in_ready;
  assign do_pop     = pop && head_valid;

  always_comb begin
    classified.op = in_item.op;
    classified.fx = ftgc_pkg::wide_t'(in_item.force_x);
    classified.fy = ftgc_pkg::wide_t'(in_item.force_y);
    classified.tx = ftgc_pkg::wide_t'(in_item.torque_x);
    classified.ty = ftgc_pkg::wide_t'(in_item.torque_y);
    // left-handed sensor: flip z, one extra bit keeps the most negative value exact
    if (right_handed) begin
      classified.fz = ftgc_pkg::wide_t'(in_item.force_z);
      classified.tz = ftgc_pkg::wide_t'(in_item.torque_z);
    end else begin
      classified.fz = -ftgc_pkg::wide_t'(in_item.force_z);
      classified.tz = -ftgc_pkg::wide_t'(in_item.torque_z);
    end
    classified.r0 = in_item.wrist_rot_row0;
    classified.r1 = in_item.wrist_rot_row1;
    classified.r2 = in_item.wrist_rot_row2;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= classified;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== design/ftgc_back.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ftgc_back
// Three-stage compensation pipeline with the reaction store and result register.
// ---------------------------------------------------------------------------
module ftgc_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  head_valid,
  input  ftgc_pkg::queue_item_t head,
  output logic                  pop,
  input  ftgc_pkg::back_cfg_t   cfg,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ftgc_pkg::out_item_t   out_item
);

  localparam int VB = ftgc_pkg::VAL_BITS;

  logic advance;

  // stage a: sensor rotation and gravity force
  logic                  a_valid;
  logic                  a_op;
  logic [2:0][VB-1:0]    a_fw;
  logic [2:0][VB-1:0]    a_tw;
  logic [2:0][VB-1:0]    a_g;
  ftgc_pkg::word_t       a_r0;
  ftgc_pkg::word_t       a_r1;
  ftgc_pkg::word_t       a_r2;

  // stage b: cross products
  logic                  b_valid;
  logic                  b_op;
  logic [2:0][VB-1:0]    b_fw;
  logic [2:0][VB-1:0]    b_tw;
  logic [2:0][VB-1:0]    b_pf;
  logic [2:0][VB-1:0]    b_g;
  logic [2:0][VB-1:0]    b_gt;
  ftgc_pkg::word_t       b_r0;
  ftgc_pkg::word_t       b_r1;
  ftgc_pkg::word_t       b_r2;

  logic [5:0][ftgc_pkg::FORCE_BITS-1:0] reaction;
  logic                                 calibrated;

  logic [2:0][VB-1:0]    fw_c;
  logic [2:0][VB-1:0]    tw_c;
  logic [2:0][VB-1:0]    g_c;
  logic [2:0][VB-1:0]    pf_c;
  logic [2:0][VB-1:0]    gt_c;
  logic [2:0][VB-1:0]    nf;
  logic [2:0][VB-1:0]    nt;
  logic [2:0][VB-1:0]    of;
  logic [2:0][VB-1:0]    ot;
  ftgc_pkg::out_item_t   result;
  ftgc_pkg::acc_t        wgt;

  assign advance = !out_valid || out_ready;
  assign pop     = advance && head_valid;

  always_comb begin
    ftgc_pkg::val_t fx;
    ftgc_pkg::val_t fy;
    ftgc_pkg::val_t fz;
    ftgc_pkg::val_t tx;
    ftgc_pkg::val_t ty;
    ftgc_pkg::val_t tz;
    fx = ftgc_pkg::val_t'(head.fx);
    fy = ftgc_pkg::val_t'(head.fy);
    fz = ftgc_pkg::val_t'(head.fz);
    tx = ftgc_pkg::val_t'(head.tx);
    ty = ftgc_pkg::val_t'(head.ty);
    tz = ftgc_pkg::val_t'(head.tz);
    fw_c[0] = ftgc_pkg::dot3(cfg.rot_row0, fx, fy, fz);
    fw_c[1] = ftgc_pkg::dot3(cfg.rot_row1, fx, fy, fz);
    fw_c[2] = ftgc_pkg::dot3(cfg.rot_row2, fx, fy, fz);
    tw_c[0] = ftgc_pkg::dot3(cfg.rot_row0, tx, ty, tz);
    tw_c[1] = ftgc_pkg::dot3(cfg.rot_row1, tx, ty, tz);
    tw_c[2] = ftgc_pkg::dot3(cfg.rot_row2, tx, ty, tz);
    wgt = ftgc_pkg::acc_t'({1'b0, cfg.weight});
    // weight down the base z axis, seen from the wrist: -W times row 2
    for (int c = 0; c < 3; c++) begin
      g_c[c] = ftgc_pkg::rnd(-(wgt * ftgc_pkg::acc_t'(ftgc_pkg::elem(head.r2, c))));
    end
  end

  always_comb begin
    pf_c[0] = ftgc_pkg::cross_c(ftgc_pkg::elem(cfg.offset, 1), a_fw[2],
                                ftgc_pkg::elem(cfg.offset, 2), a_fw[1]);
    pf_c[1] = ftgc_pkg::cross_c(ftgc_pkg::elem(cfg.offset, 2), a_fw[0],
                                ftgc_pkg::elem(cfg.offset, 0), a_fw[2]);
    pf_c[2] = ftgc_pkg::cross_c(ftgc_pkg::elem(cfg.offset, 0), a_fw[1],
                                ftgc_pkg::elem(cfg.offset, 1), a_fw[0]);
    gt_c[0] = ftgc_pkg::cross_c(ftgc_pkg::elem(cfg.grav_point, 1), a_g[2],
                                ftgc_pkg::elem(cfg.grav_point, 2), a_g[1]);
    gt_c[1] = ftgc_pkg::cross_c(ftgc_pkg::elem(cfg.grav_point, 2), a_g[0],
                                ftgc_pkg::elem(cfg.grav_point, 0), a_g[2]);
    gt_c[2] = ftgc_pkg::cross_c(ftgc_pkg::elem(cfg.grav_point, 0), a_g[1],
                                ftgc_pkg::elem(cfg.grav_point, 1), a_g[0]);
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      nf[k] = $signed(b_g[k]) + ftgc_pkg::val_t'($signed(reaction[k]))
              - $signed(b_fw[k]);
      nt[k] = $signed(b_gt[k]) + ftgc_pkg::val_t'($signed(reaction[3+k]))
              - $signed(b_tw[k]) - $signed(b_pf[k]);
    end
    of[0] = ftgc_pkg::dot3(b_r0, nf[0], nf[1], nf[2]);
    of[1] = ftgc_pkg::dot3(b_r1, nf[0], nf[1], nf[2]);
    of[2] = ftgc_pkg::dot3(b_r2, nf[0], nf[1], nf[2]);
    ot[0] = ftgc_pkg::dot3(b_r0, nt[0], nt[1], nt[2]);
    ot[1] = ftgc_pkg::dot3(b_r1, nt[0], nt[1], nt[2]);
    ot[2] = ftgc_pkg::dot3(b_r2, nt[0], nt[1], nt[2]);
    result = '0;
    if (b_op == ftgc_pkg::OP_MEASURE && calibrated) begin
      result.out_force_x  = ftgc_pkg::sat(of[0]);
      result.out_force_y  = ftgc_pkg::sat(of[1]);
      result.out_force_z  = ftgc_pkg::sat(of[2]);
      result.out_torque_x = ftgc_pkg::sat(ot[0]);
      result.out_torque_y = ftgc_pkg::sat(ot[1]);
      result.out_torque_z = ftgc_pkg::sat(ot[2]);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      a_op  <= head.op;
      a_fw  <= fw_c;
      a_tw  <= tw_c;
      a_g   <= g_c;
      a_r0  <= head.r0;
      a_r1  <= head.r1;
      a_r2  <= head.r2;
      b_op  <= a_op;
      b_fw  <= a_fw;
      b_tw  <= a_tw;
      b_pf  <= pf_c;
      b_g   <= a_g;
      b_gt  <= gt_c;
      b_r0  <= a_r0;
      b_r1  <= a_r1;
      b_r2  <= a_r2;
      out_item <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid    <= 1'b0;
      b_valid    <= 1'b0;
      out_valid  <= 1'b0;
      calibrated <= 1'b0;
      reaction   <= '0;
    end else if (advance) begin
      a_valid   <= head_valid;
      b_valid   <= a_valid;
      out_valid <= b_valid;
      // reaction is the negated gravity wrench at the calibration pose
      if (b_valid && b_op == ftgc_pkg::OP_CALIBRATE) begin
        for (int k = 0; k < 3; k++) begin
          reaction[k]   <= ftgc_pkg::sat(-$signed(b_g[k]));
          reaction[3+k] <= ftgc_pkg::sat(-$signed(b_gt[k]));
        end
        calibrated <= 1'b1;
      end
    end
  end

endmodule

// ===== design/ftgc_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ftgc_checker
// Port-level checks on the gravity compensation block, bound to the top level.
// ---------------------------------------------------------------------------
`include "force_torque_gravity_compensation_assert.svh"

module ftgc_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input ftgc_pkg::in_item_t                in_item,
  input logic                              out_valid,
  input logic                              out_ready,
  input ftgc_pkg::out_item_t               out_item,
  input logic                              cfg_we,
  input logic [ftgc_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input logic [ftgc_pkg::WORD_BITS-1:0]    cfg_data
);

  // a stalled result stays put
  `FTGC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_item))

  // the queue only fills up behind a stalled result
  `FTGC_ASSERT_IMPL(a_full_means_stall, !in_ready, out_valid)

  // reset leaves an empty, accepting block
  `FTGC_ASSERT_NEXT_ALWAYS(a_reset_empty, rst, in_ready && !out_valid)

endmodule

bind force_torque_gravity_compensation ftgc_checker u_ftgc_checker (.*);

// ===== verif/ftgc_wrench_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ftgc_wrench_checker
// Watches the config, input and output channels of the gravity compensation
// block, predicts each compensated wrench and compares it field by field.
// ---------------------------------------------------------------------------
module ftgc_wrench_checker
  import ftgc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  in_item_t                in_item,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  out_item_t               out_item,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [WORD_BITS-1:0]    cfg_data,
  output int                      errors,
  output int                      outstanding
);

  typedef longint vec3_t[3];

  word_t                 s_rot[3];
  word_t                 s_offset;
  logic [FORCE_BITS-2:0] s_weight;
  word_t                 s_grav_point;
  logic                  s_right_handed;
  longint                reaction[6];
  logic                  calibrated;
  out_item_t             pending_wrench[$];

  function automatic longint part(word_t w, int c);
    return longint'($signed(w[WORD_BITS-1-ELEM_BITS*c -: ELEM_BITS]));
  endfunction

  // one rounding per dot or cross component, half up
  function automatic longint round_q(longint x);
    return (x + (64'sd1 <<< (ROT_FRAC_BITS - 1))) >>> ROT_FRAC_BITS;
  endfunction

  function automatic longint clamp(longint x);
    longint hi;
    hi = (64'sd1 <<< (FORCE_BITS - 1)) - 1;
    if (x > hi) return hi;
    if (x < -hi - 1) return -hi - 1;
    return x;
  endfunction

  function automatic vec3_t rot3(word_t r0, word_t r1, word_t r2, vec3_t v);
    vec3_t o;
    word_t rows[3];
    rows = '{r0, r1, r2};
    for (int i = 0; i < 3; i++) begin
      o[i] = round_q(part(rows[i], 0) * v[0] + part(rows[i], 1) * v[1] +
                     part(rows[i], 2) * v[2]);
    end
    return o;
  endfunction

  function automatic vec3_t cross3(word_t p, vec3_t v);
    vec3_t o;
    o[0] = round_q(part(p, 1) * v[2] - part(p, 2) * v[1]);
    o[1] = round_q(part(p, 2) * v[0] - part(p, 0) * v[2]);
    o[2] = round_q(part(p, 0) * v[1] - part(p, 1) * v[0]);
    return o;
  endfunction

  function automatic vec3_t tool_gravity(word_t row2);
    vec3_t g;
    for (int c = 0; c < 3; c++) begin
      g[c] = round_q(-(longint'(s_weight) * part(row2, c)));
    end
    return g;
  endfunction

  function automatic out_item_t compensate_wrench(in_item_t it);
    out_item_t res;
    vec3_t f, t, fw, tw, pf, g, gt, nf, nt, of, ot;
    res = '0;
    g = tool_gravity(it.wrist_rot_row2);
    gt = cross3(s_grav_point, g);
    if (it.op == OP_CALIBRATE) begin
      for (int k = 0; k < 3; k++) begin
        reaction[k] = clamp(-g[k]);
        reaction[3 + k] = clamp(-gt[k]);
      end
      calibrated = 1'b1;
      return res;
    end
    if (!calibrated) return res;
    f = '{longint'(it.force_x), longint'(it.force_y), longint'(it.force_z)};
    t = '{longint'(it.torque_x), longint'(it.torque_y), longint'(it.torque_z)};
    if (!s_right_handed) begin
      f[2] = -f[2];
      t[2] = -t[2];
    end
    fw = rot3(s_rot[0], s_rot[1], s_rot[2], f);
    tw = rot3(s_rot[0], s_rot[1], s_rot[2], t);
    pf = cross3(s_offset, fw);
    for (int k = 0; k < 3; k++) begin
      nf[k] = -(fw[k] - g[k] - reaction[k]);
      nt[k] = -(tw[k] + pf[k] - gt[k] - reaction[3 + k]);
    end
    of = rot3(it.wrist_rot_row0, it.wrist_rot_row1, it.wrist_rot_row2, nf);
    ot = rot3(it.wrist_rot_row0, it.wrist_rot_row1, it.wrist_rot_row2, nt);
    res.out_force_x  = force_t'(clamp(of[0]));
    res.out_force_y  = force_t'(clamp(of[1]));
    res.out_force_z  = force_t'(clamp(of[2]));
    res.out_torque_x = force_t'(clamp(ot[0]));
    res.out_torque_y = force_t'(clamp(ot[1]));
    res.out_torque_z = force_t'(clamp(ot[2]));
    return res;
  endfunction

  task automatic check_field(string name, force_t exp_v, force_t act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  assign outstanding = pending_wrench.size();

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      s_rot = '{ROT_ROW0_RESET, ROT_ROW1_RESET, ROT_ROW2_RESET};
      s_offset = '0;
      s_weight = '0;
      s_grav_point = '0;
      s_right_handed = 1'b1;
      reaction = '{default: 0};
      calibrated = 1'b0;
      errors = 0;
      pending_wrench.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SENSOR_ROT_ROW0: s_rot[0] = cfg_data;
          REG_SENSOR_ROT_ROW1: s_rot[1] = cfg_data;
          REG_SENSOR_ROT_ROW2: s_rot[2] = cfg_data;
          REG_SENSOR_OFFSET:   s_offset = cfg_data;
          REG_TOOL_WEIGHT:     s_weight = cfg_data[FORCE_BITS-2:0];
          REG_GRAVITY_POINT:   s_grav_point = cfg_data;
          REG_RIGHT_HANDED:    s_right_handed = cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (pending_wrench.size() == 0) begin
          $error("result item with no expectation waiting");
          errors++;
        end else begin
          want = pending_wrench.pop_front();
          check_field("out_force_x", want.out_force_x, out_item.out_force_x);
          check_field("out_force_y", want.out_force_y, out_item.out_force_y);
          check_field("out_force_z", want.out_force_z, out_item.out_force_z);
          check_field("out_torque_x", want.out_torque_x, out_item.out_torque_x);
          check_field("out_torque_y", want.out_torque_y, out_item.out_torque_y);
          check_field("out_torque_z", want.out_torque_z, out_item.out_torque_z);
        end
      end
      if (in_valid && in_ready) pending_wrench.push_back(compensate_wrench(in_item));
    end
  end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Drives config phases and directed plus random wrench items with random
// idling on both channels; the checker predicts and compares every result.
// ---------------------------------------------------------------------------
module tb_top;
  import ftgc_pkg::*;

  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 240;
  localparam int STALL_LIMIT = 5000;

  logic                    clk;
  logic                    rst;
  logic                    in_valid;
  logic                    in_ready;
  in_item_t                in_item;
  logic                    out_valid;
  logic                    out_ready;
  out_item_t               out_item;
  logic                    cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [WORD_BITS-1:0]    cfg_data;
  int                      errors;
  int                      outstanding;
  bit                      tx_idle;
  bit                      rx_idle;
  bit                      hold_req;
  bit                      hold_done;
  int                      quiet_cycles;

  force_torque_gravity_compensation dut (.*);

  ftgc_wrench_checker checker_i (.*);

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic logic [ELEM_BITS-1:0] pick_elem();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h4000;
      3: return 16'hC000;
      4: return '0;
      5: return 16'($urandom_range(0, 1023)) - 16'd512;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic word_t pick_word();
    if ($urandom_range(0, 4) == 0) return {16'($urandom), 32'($urandom)};
    return {pick_elem(), pick_elem(), pick_elem()};
  endfunction

  function automatic force_t pick_force();
    case ($urandom_range(0, 5))
      0: return force_t'(24'h800000);
      1: return force_t'(24'h7FFFFF);
      2: return force_t'($urandom_range(0, 8191)) - force_t'(4096);
      default: return force_t'($urandom);
    endcase
  endfunction

  function automatic in_item_t pick_item();
    in_item_t it;
    it.op = ($urandom_range(0, 7) == 0) ? OP_CALIBRATE : OP_MEASURE;
    it.force_x = pick_force();
    it.force_y = pick_force();
    it.force_z = pick_force();
    it.torque_x = pick_force();
    it.torque_y = pick_force();
    it.torque_z = pick_force();
    it.wrist_rot_row0 = pick_word();
    it.wrist_rot_row1 = pick_word();
    it.wrist_rot_row2 = pick_word();
    return it;
  endfunction

  function automatic in_item_t make_item(logic op, force_t v, word_t r0, word_t r1,
                                         word_t r2);
    return '{op, v, v, v, v, v, v, r0, r1, r2};
  endfunction

  task automatic send_item(in_item_t it);
    if (tx_idle && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [WORD_BITS-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  // block must be drained before registers change
  task automatic drain();
    in_valid <= 1'b0;
    // let the checker record the last accepted item first
    @(negedge clk);
    wait (outstanding == 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic load_setting(int mode);
    case (mode)
      1: begin
        write_reg(REG_SENSOR_ROT_ROW0, ROT_ROW0_RESET);
        write_reg(REG_SENSOR_ROT_ROW1, ROT_ROW1_RESET);
        write_reg(REG_SENSOR_ROT_ROW2, ROT_ROW2_RESET);
        write_reg(REG_SENSOR_OFFSET, {16'h0800, 16'hF800, 16'h0400});
        write_reg(REG_TOOL_WEIGHT, 48'd2560);
        write_reg(REG_GRAVITY_POINT, {16'h0100, 16'h0000, 16'h1000});
        write_reg(REG_RIGHT_HANDED, 48'd1);
      end
      2: begin
        for (int i = 0; i < 6; i++) write_reg(i[CFG_IDX_BITS-1:0], '1);
        write_reg(REG_RIGHT_HANDED, '1);
      end
      3: begin
        for (int i = 0; i < 6; i++) begin
          write_reg(i[CFG_IDX_BITS-1:0], {3{16'h8000}});
        end
        write_reg(REG_TOOL_WEIGHT, 48'h7FFFFF);
        write_reg(REG_RIGHT_HANDED, 48'd0);
      end
      4: begin
        for (int i = 0; i < 6; i++) write_reg(i[CFG_IDX_BITS-1:0], '0);
        write_reg(REG_RIGHT_HANDED, 48'hFFFF_FFFF_FFFE);
      end
      default: begin
        for (int i = 0; i < 7; i++) begin
          write_reg(i[CFG_IDX_BITS-1:0], {16'($urandom), 32'($urandom)});
        end
        write_reg(3'd7, {16'($urandom), 32'($urandom)});
      end
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // receiver: random stalls, plus one long hold so the queue backs up
  initial begin
    @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_done = 1'b1;
      end else if (rx_idle && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("force_torque_gravity_compensation: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    word_t id0;
    word_t id1;
    word_t id2;
    id0 = ROT_ROW0_RESET;
    id1 = ROT_ROW1_RESET;
    id2 = ROT_ROW2_RESET;
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    hold_req = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // not yet calibrated: results must be zero
    send_item(make_item(OP_MEASURE, force_t'(24'h7FFFFF), id0, id1, id2));
    send_item(make_item(OP_MEASURE, force_t'(24'h800000), '1, '1, '1));
    drain();
    load_setting(1);
    send_item(make_item(OP_CALIBRATE, '0, id0, id1, id2));
    send_item(make_item(OP_MEASURE, '0, id0, id1, id2));
    send_item(make_item(OP_MEASURE, force_t'(24'h7FFFFF), id0, id1, id2));
    send_item(make_item(OP_MEASURE, force_t'(24'h800000), id0, id1, id2));
    send_item(make_item(OP_MEASURE, force_t'(24'h000100), id2, id1, id0));
    // recalibrate at a different pose while already calibrated
    send_item(make_item(OP_CALIBRATE, '0, id1, id2, {16'h0, 16'hC000, 16'h0}));
    send_item(make_item(OP_MEASURE, force_t'(24'h7FFFFF), '1, {3{16'h8000}}, '0));
    // non-orthonormal rotation taken as given
    send_item(make_item(OP_MEASURE, force_t'(24'h012345), {3{16'h7FFF}},
                        {3{16'h7FFF}}, {3{16'h7FFF}}));
    drain();
    load_setting(3);
    send_item(make_item(OP_MEASURE, force_t'(24'h800000), id0, id1, id2));
    send_item(make_item(OP_CALIBRATE, '0, {3{16'h8000}}, '1, {3{16'h8000}}));
    // left-handed sensor with most negative z
    send_item(make_item(OP_MEASURE, force_t'(24'h800000), id0, id1, id2));
    send_item(make_item(OP_MEASURE, force_t'(24'h7FFFFF), {3{16'h8000}},
                        {3{16'h8000}}, {3{16'h8000}}));
    drain();

    for (int p = 0; p < PHASES; p++) begin
      load_setting((p < 4) ? p + 1 : 0);
      if (p == PHASES - 1) begin
        tx_idle = 1'b0;
        rx_idle = 1'b0;
      end
      if (p == 1) begin
        tx_idle = 1'b0;
        hold_req = 1'b1;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 1 && n == 40) tx_idle = 1'b1;
        send_item(pick_item());
      end
      drain();
    end

    if (errors == 0) begin
      $display("force_torque_gravity_compensation: match");
    end else begin
      $display("force_torque_gravity_compensation: mismatch");
    end
    $finish;
  end

endmodule
